@@ design/midi_serial_bridge_defines.svh @@
// Assertion macros for the MIDI serial bridge.
// Included by files that carry concurrent checks; depends on nothing else.
`ifndef MIDI_SERIAL_BRIDGE_DEFINES_SVH
`define MIDI_SERIAL_BRIDGE_DEFINES_SVH
`ifndef SYNTHESIS
// Check that a property holds at every rising edge outside reset
`define MSB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never occurs outside reset
`define MSB_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define MSB_ASSERT(lbl, clk, rst, prop, msg)
`define MSB_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

@@ design/msb_pkg.sv @@
// Shared types and constants of the MIDI serial bridge.
// No dependencies; imported by the top level.
`default_nettype none
package msb_pkg;

   // Item modes
   typedef enum logic [1:0] {
      MODE_PUSH = 2'd0,
      MODE_TICK = 2'd1,
      MODE_RECV = 2'd2
   } mode_type;

   // Serial control arming: external clock selected and transfer started
   localparam logic [7:0] ARM_MASK  = 8'h81;
   localparam logic [7:0] ARM_VALUE = 8'h80;

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;
   localparam logic [2:0] RECV_LAST     = 3'd7;

   // Register port
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int CSR_IDX_W = CSR_AW - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_ENABLE = '0;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] host_byte;
      logic [7:0] serial_control;
      logic       bit_in;
   } req_type;

   typedef struct packed {
      logic       bit_out_valid;
      logic       bit_out;
      logic       rx_byte_valid;
      logic [7:0] rx_byte;
      logic       byte_dropped;
      logic       not_enabled;
   } rsp_type;

endpackage
`default_nettype wire

@@ design/midi_serial_bridge.sv @@
// MIDI serial bridge: accepts one transaction per cycle when the result side keeps up,
// and returns one result per transaction, held first in the input register and then in
// the result register. Host bytes wait in a ring of RING_DEPTH entries (RING_DEPTH-1
// usable) held in one RAM; the oldest byte is kept in a head register so a tick can
// load it at once, and after a load the next head is fetched from the RAM in the
// following cycle, well before the eight ticks that the byte in flight takes. The ring
// needs no clearing pass after reset.
// Depends on msb_pkg, msb_ram and midi_serial_bridge_defines.svh.
`default_nettype none
`include "midi_serial_bridge_defines.svh"
module midi_serial_bridge
   import msb_pkg::*;
#(
   parameter int RING_DEPTH = 256
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // Input channel
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_mode,
   input  wire logic [7:0]          req_host_byte,
   input  wire logic [7:0]          req_serial_control,
   input  wire logic                req_bit_in,
   // Result channel
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic                     rsp_bit_out_valid,
   output logic                     rsp_bit_out,
   output logic                     rsp_rx_byte_valid,
   output logic [7:0]               rsp_rx_byte,
   output logic                     rsp_byte_dropped,
   output logic                     rsp_not_enabled,
   // Register port
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [CSR_AW-1:0]   paddr,
   input  wire logic [CSR_DW-1:0]   pwdata,
   output logic      [CSR_DW-1:0]   prdata,
   output logic                     pready
);

   localparam int AW = $clog2(RING_DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

   // Pipeline registers
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_ff, out_in;
   logic    advance;

   // Block state
   logic          enabled_ff, enabled_in;
   logic [AW-1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [AW-1:0] rd_next, wr_next;
   logic [7:0]    head_ff, head_in;
   logic          refill_ff, refill_in;
   logic [7:0]    send_shift_ff, send_shift_in;
   logic [3:0]    send_left_ff, send_left_in;
   logic [7:0]    recv_shift_ff, recv_shift_in;
   logic [2:0]    recv_count_ff, recv_count_in;

   // Ring and datapath helpers
   logic       ring_empty, ring_full, armed, load, send;
   logic [7:0] shift_src, recv_new;
   logic [3:0] left_src;
   logic       ram_we;
   logic [7:0] ram_rd_data;
   logic       csr_wr;

   // Advance the input register into the result register
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Ring pointers wrap at the ring depth
   assign rd_next    = (rd_ff == LAST_IDX) ? '0 : rd_ff + AW'(1);
   assign wr_next    = (wr_ff == LAST_IDX) ? '0 : wr_ff + AW'(1);
   assign ring_empty = (rd_ff == wr_ff);
   assign ring_full  = (wr_next == rd_ff);

   // Tick: load the head when nothing is in flight, then send the top bit
   assign armed     = ((in_ff.serial_control & ARM_MASK) == ARM_VALUE);
   assign load      = armed && (send_left_ff == '0) && !ring_empty;
   assign send      = armed && ((send_left_ff != '0) || !ring_empty);
   assign shift_src = load ? head_ff : send_shift_ff;
   assign left_src  = load ? BITS_PER_BYTE : send_left_ff;
   assign recv_new  = {recv_shift_ff[6:0], in_ff.bit_in};

   // Process the held transaction
   always_comb begin
      out_in        = '0;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      head_in       = refill_ff ? ram_rd_data : head_ff;
      refill_in     = 1'b0;
      send_shift_in = send_shift_ff;
      send_left_in  = send_left_ff;
      recv_shift_in = recv_shift_ff;
      recv_count_in = recv_count_ff;
      ram_we        = 1'b0;
      if (!enabled_ff) begin
         out_in.not_enabled = 1'b1;
      end else begin
         unique case (in_ff.mode)
            MODE_PUSH: begin
               if (ring_full) begin
                  out_in.byte_dropped = 1'b1;
               end else begin
                  ram_we = advance;
                  wr_in  = wr_next;
                  // Bypass the RAM when the ring is empty
                  if (ring_empty) begin
                     head_in = in_ff.host_byte;
                  end
               end
            end
            MODE_TICK: begin
               if (send) begin
                  out_in.bit_out_valid = 1'b1;
                  out_in.bit_out       = shift_src[7];
                  send_shift_in        = {shift_src[6:0], 1'b0};
                  send_left_in         = left_src - 4'd1;
                  if (load) begin
                     rd_in     = rd_next;
                     refill_in = (rd_next != wr_ff);
                  end
               end
            end
            MODE_RECV: begin
               if (recv_count_ff == RECV_LAST) begin
                  out_in.rx_byte_valid = 1'b1;
                  out_in.rx_byte       = recv_new;
                  recv_shift_in        = '0;
                  recv_count_in        = '0;
               end else begin
                  recv_shift_in = recv_new;
                  recv_count_in = recv_count_ff + 3'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Byte ring; the read port always fetches the entry after the head
   msb_ram #(
      .WIDTH(8),
      .DEPTH(RING_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(wr_ff),
      .wr_data(in_ff.host_byte),
      .rd_addr(rd_next),
      .rd_data(ram_rd_data)
   );

   // Register port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      enabled_in = enabled_ff;
      if (csr_wr && (paddr[CSR_AW-1:2] == CSR_IDX_ENABLE)) begin
         enabled_in = pwdata[0];
      end
      prdata = '0;
      if (paddr[CSR_AW-1:2] == CSR_IDX_ENABLE) begin
         prdata[0] = enabled_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         enabled_ff    <= 1'b0;
         rd_ff         <= '0;
         wr_ff         <= '0;
         refill_ff     <= 1'b0;
         send_shift_ff <= '0;
         send_left_ff  <= '0;
         recv_shift_ff <= '0;
         recv_count_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         enabled_ff   <= enabled_in;
         refill_ff    <= advance ? refill_in : 1'b0;
         if (advance) begin
            rd_ff         <= rd_in;
            wr_ff         <= wr_in;
            send_shift_ff <= send_shift_in;
            send_left_ff  <= send_left_in;
            recv_shift_ff <= recv_shift_in;
            recv_count_ff <= recv_count_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= '{mode: req_mode, host_byte: req_host_byte,
                    serial_control: req_serial_control, bit_in: req_bit_in};
      end
      if (advance) begin
         out_ff  <= out_in;
         head_ff <= head_in;
      end else if (refill_ff) begin
         head_ff <= ram_rd_data;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_bit_out_valid = out_ff.bit_out_valid;
   assign rsp_bit_out       = out_ff.bit_out;
   assign rsp_rx_byte_valid = out_ff.rx_byte_valid;
   assign rsp_rx_byte       = out_ff.rx_byte;
   assign rsp_byte_dropped  = out_ff.byte_dropped;
   assign rsp_not_enabled   = out_ff.not_enabled;

   // Head refill must land before the next load from the ring
   `MSB_ASSERT_NEVER(a_load_during_refill, clock, reset, advance && enabled_ff && (in_ff.mode == MODE_TICK) && load && refill_ff, "ring load while head refill pending")
   // A pending refill implies the ring still holds a byte
   `MSB_ASSERT(a_refill_nonempty, clock, reset, refill_ff |-> (rd_ff != wr_ff), "head refill with empty ring")
   // Bits in flight never exceed one byte
   `MSB_ASSERT(a_send_left_range, clock, reset, send_left_ff <= BITS_PER_BYTE, "send bit count out of range")

endmodule
`default_nettype wire

@@ design/msb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the bridge's byte ring.
`default_nettype none
module msb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write one entry when wr_en is set, read one entry every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire
